// ===== hw/rtl/icc_pkg.sv =====
package icc_pkg;

  localparam int unsigned OpW      = 2;
  localparam int unsigned RegIdxW  = 3;
  localparam int unsigned CfgDataW = 17;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 32;
  localparam int unsigned TimeW    = 17;
  localparam int unsigned TempW    = 11;
  localparam int unsigned HumW     = 10;
  localparam int unsigned BandW    = 8;
  localparam int unsigned DayW     = 8;

  localparam int unsigned SecPerMin  = 60;
  localparam int unsigned SecPerHour = 3600;

  typedef enum logic [OpW-1:0] {
    OP_SAMPLE = 2'd0,
    OP_TICK   = 2'd1,
    OP_SWITCH = 2'd2
  } icc_op_e;

  localparam logic [RegIdxW-1:0] REG_SETTER_TEMP  = 3'd0;
  localparam logic [RegIdxW-1:0] REG_HATCHER_TEMP = 3'd1;
  localparam logic [RegIdxW-1:0] REG_SETTER_HUM   = 3'd2;
  localparam logic [RegIdxW-1:0] REG_HATCHER_HUM  = 3'd3;
  localparam logic [RegIdxW-1:0] REG_TEMP_BAND    = 3'd4;
  localparam logic [RegIdxW-1:0] REG_HUM_BAND     = 3'd5;
  localparam logic [RegIdxW-1:0] REG_FAN_DELAY    = 3'd6;
  localparam logic [RegIdxW-1:0] REG_SETTER_DAYS  = 3'd7;

  typedef struct packed {
    logic phase;
    logic rotate;
    logic vent;
    logic fan;
    logic humid;
    logic heater;
  } icc_drive_t;

  // True when more than lim seconds have passed; an earlier "now" counts as a wrap.
  function automatic logic elapsed_gt(input logic [TimeW-1:0] now,
                                      input logic [TimeW-1:0] since,
                                      input logic [TimeW-1:0] lim);
    logic [TimeW-1:0] diff;
    diff = now - since;
    return (now < since) || (diff > lim);
  endfunction

  function automatic logic elapsed_ge(input logic [TimeW-1:0] now,
                                      input logic [TimeW-1:0] since,
                                      input logic [TimeW-1:0] lim);
    logic [TimeW-1:0] diff;
    diff = now - since;
    return (now < since) || (diff >= lim);
  endfunction

endpackage

// ===== hw/rtl/incubator_climate_controller_core.sv =====
// A result beat is loaded into the output register, or into the skid entry on a stall.
// One input beat per cycle while the skid is empty; each is processed in one pass.
// A two-entry output buffer lets one more beat be accepted while a result is stalled.
// The averaging rings use one memory write and one registered prefetch read per sample.
// Reset is asynchronous and active low: drives, sums, ring position and output valids
// clear, and the configuration registers return to their default setpoints.
module incubator_climate_controller_core #(
  parameter int unsigned AVG_DEPTH             = 8,
  parameter int unsigned VENT_TEMP_MARGIN      = 10,
  parameter int unsigned VENT_HUM_MARGIN       = 100,
  parameter int unsigned ROTATE_EVERY_HOURS    = 2,
  parameter int unsigned ROTATE_IGNORE_SECONDS = 10,
  parameter int unsigned HEATER_FAN_WAIT       = 30
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [icc_pkg::RegIdxW-1:0]   cfg_idx_i,
  input  logic [icc_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // Fields from bit 0: temp_sample, hum_sample, day, hour, minute, second, zero fill.
  input  logic [icc_pkg::InDataW-1:0]   s_axis_tdata,
  // Fields from bit 0: op.
  input  logic [icc_pkg::OpW-1:0]       s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // Fields from bit 0: heater_on, humidifier_on, fan_on, vent_on, rotate_on,
  // hatcher_phase, mean_temp, mean_hum, zero fill.
  output logic [icc_pkg::OutDataW-1:0]  m_axis_tdata
);
  import icc_pkg::*;

  localparam int unsigned PosW = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int unsigned TsW  = TempW + $clog2(AVG_DEPTH);
  localparam int unsigned HsW  = HumW + $clog2(AVG_DEPTH);
  localparam int unsigned CmpW = 14 + $clog2(AVG_DEPTH);

  localparam logic [PosW-1:0]        LastPos = PosW'(AVG_DEPTH - 1);
  localparam logic signed [CmpW-1:0] DepthC  = CmpW'(AVG_DEPTH);
  localparam logic signed [CmpW-1:0] VentTC  = CmpW'(VENT_TEMP_MARGIN);
  localparam logic signed [CmpW-1:0] VentHC  = CmpW'(VENT_HUM_MARGIN);
  localparam logic [TimeW-1:0]       WaitC   = TimeW'(HEATER_FAN_WAIT);
  localparam logic [TimeW-1:0]       IgnoreC = TimeW'(ROTATE_IGNORE_SECONDS);

  function automatic logic [31:0] rot_hours_mask();
    logic [31:0] m;
    int unsigned c;
    m = '0;
    c = 0;
    for (int unsigned i = 0; i < 32; i++) begin
      m[i] = (c == 0);
      c++;
      if (c == ROTATE_EVERY_HOURS) begin
        c = 0;
      end
    end
    return m;
  endfunction

  localparam logic [31:0] RotMask = rot_hours_mask();

  // Configuration registers.
  logic signed [TempW-1:0] setter_temp_q, hatcher_temp_q;
  logic [HumW-1:0]         setter_hum_q, hatcher_hum_q;
  logic [BandW-1:0]        temp_band_q, hum_band_q;
  logic [TimeW-1:0]        fan_delay_q;
  logic [DayW-1:0]         setter_days_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setter_temp_q  <= 11'sd377;
      hatcher_temp_q <= 11'sd370;
      setter_hum_q   <= 10'd550;
      hatcher_hum_q  <= 10'd700;
      temp_band_q    <= 8'd2;
      hum_band_q     <= 8'd20;
      fan_delay_q    <= 17'd10;
      setter_days_q  <= 8'd18;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SETTER_TEMP:  setter_temp_q  <= cfg_data_i[TempW-1:0];
        REG_HATCHER_TEMP: hatcher_temp_q <= cfg_data_i[TempW-1:0];
        REG_SETTER_HUM:   setter_hum_q   <= cfg_data_i[HumW-1:0];
        REG_HATCHER_HUM:  hatcher_hum_q  <= cfg_data_i[HumW-1:0];
        REG_TEMP_BAND:    temp_band_q    <= cfg_data_i[BandW-1:0];
        REG_HUM_BAND:     hum_band_q     <= cfg_data_i[BandW-1:0];
        REG_FAN_DELAY:    fan_delay_q    <= cfg_data_i[TimeW-1:0];
        REG_SETTER_DAYS:  setter_days_q  <= cfg_data_i[DayW-1:0];
        default: ;
      endcase
    end
  end

  // Input fields.
  logic                    s_fire;
  icc_op_e                 op;
  logic signed [TempW-1:0] temp_sample;
  logic [HumW-1:0]         hum_sample;
  logic [DayW-1:0]         day;
  logic [4:0]              hour;
  logic [5:0]              minute;
  logic [5:0]              second;
  logic [TimeW-1:0]        now;

  assign s_fire      = s_axis_tvalid & s_axis_tready;
  assign op          = icc_op_e'(s_axis_tuser);
  assign temp_sample = s_axis_tdata[10:0];
  assign hum_sample  = s_axis_tdata[20:11];
  assign day         = s_axis_tdata[28:21];
  assign hour        = s_axis_tdata[33:29];
  assign minute      = s_axis_tdata[39:34];
  assign second      = s_axis_tdata[45:40];
  assign now = TimeW'(second) + TimeW'(minute) * TimeW'(SecPerMin)
             + TimeW'(hour) * TimeW'(SecPerHour);

  // Controller state.
  logic signed [TsW-1:0] tsum_q, tsum_d;
  logic [HsW-1:0]        hsum_q, hsum_d;
  logic [PosW-1:0]       pos_q, pos_d;
  logic                  wrapped_q, wrapped_d;
  logic                  heater_q, heater_d, hdprev_q, hdprev_d;
  logic                  humid_q, humid_d;
  logic                  fan_q, fan_d, fdprev_q, fdprev_d;
  logic                  vent_q, vent_d, rotate_q, rotate_d, phase_q, phase_d;
  logic [TimeW-1:0]      hsince_q, hsince_d, fsince_q, fsince_d, rsince_q, rsince_d;

  // Averaging rings; rd_*_q holds the entry at pos_q, prefetched on the previous sample.
  logic signed [TempW-1:0] temp_mem [AVG_DEPTH];
  logic [HumW-1:0]         hum_mem [AVG_DEPTH];
  logic signed [TempW-1:0] rd_temp_q, old_temp;
  logic [HumW-1:0]         rd_hum_q, old_hum;
  logic                    sample_we;

  assign sample_we = s_fire && (op == OP_SAMPLE);
  assign old_temp  = wrapped_q ? rd_temp_q : '0;
  assign old_hum   = wrapped_q ? rd_hum_q : '0;

  always_ff @(posedge clk_i) begin
    if (sample_we) begin
      temp_mem[pos_q] <= temp_sample;
      hum_mem[pos_q]  <= hum_sample;
      if (pos_d == pos_q) begin
        rd_temp_q <= temp_sample;
        rd_hum_q  <= hum_sample;
      end else begin
        rd_temp_q <= temp_mem[pos_d];
        rd_hum_q  <= hum_mem[pos_d];
      end
    end
  end

  // Tick decisions.
  logic                    setter;
  logic signed [TempW-1:0] tsp;
  logic [HumW-1:0]         hsp;
  logic signed [CmpW-1:0]  tsum_w, hsum_w, tsp_w, hsp_w, tband_w, hband_w;
  logic signed [CmpW-1:0]  t_lo, t_hi, t_vent, h_lo, h_hi, h_vent;
  logic                    hd, heater_n, humid_n, fd, fan_n, vent_n, rot_start;
  logic [TimeW-1:0]        hsince_n, fsince_n;

  assign setter  = ($signed({2'b00, day}) - 10'sd1) < $signed({2'b00, setter_days_q});
  assign tsp     = setter ? setter_temp_q : hatcher_temp_q;
  assign hsp     = setter ? setter_hum_q : hatcher_hum_q;
  assign tsum_w  = CmpW'(tsum_q);
  assign hsum_w  = CmpW'($signed({1'b0, hsum_q}));
  assign tsp_w   = CmpW'(tsp);
  assign hsp_w   = CmpW'($signed({1'b0, hsp}));
  assign tband_w = CmpW'($signed({1'b0, temp_band_q}));
  assign hband_w = CmpW'($signed({1'b0, hum_band_q}));
  assign t_lo    = (tsp_w - tband_w) * DepthC;
  assign t_hi    = (tsp_w + tband_w) * DepthC;
  assign t_vent  = (tsp_w + VentTC) * DepthC;
  assign h_lo    = (hsp_w - hband_w) * DepthC;
  assign h_hi    = (hsp_w + hband_w) * DepthC;
  assign h_vent  = (hsp_w + VentHC) * DepthC;

  assign hd        = heater_q ? !(tsum_w > t_hi) : (tsum_w < t_lo);
  assign hsince_n  = (hd != hdprev_q) ? now : hsince_q;
  assign heater_n  = hd & ~((hd != heater_q) & ~fan_q & elapsed_gt(now, hsince_n, WaitC));
  assign humid_n   = humid_q ? !(hsum_w > h_hi) : (hsum_w < h_lo);
  assign fd        = heater_n | humid_n;
  assign fsince_n  = (fd != fdprev_q) ? now : fsince_q;
  assign fan_n     = ((fan_q != fd) && elapsed_gt(now, fsince_n, fan_delay_q)) ? fd : fan_q;
  assign vent_n    = (tsum_w > t_vent) || (hsum_w > h_vent);
  assign rot_start = setter && RotMask[hour] && (minute == '0) && (second == '0);

  always_comb begin
    tsum_d    = tsum_q;
    hsum_d    = hsum_q;
    pos_d     = (pos_q == LastPos) ? '0 : pos_q + 1'b1;
    wrapped_d = wrapped_q;
    heater_d  = heater_q;
    hdprev_d  = hdprev_q;
    humid_d   = humid_q;
    fan_d     = fan_q;
    fdprev_d  = fdprev_q;
    vent_d    = vent_q;
    rotate_d  = rotate_q;
    phase_d   = phase_q;
    hsince_d  = hsince_q;
    fsince_d  = fsince_q;
    rsince_d  = rsince_q;
    case (op)
      OP_SAMPLE: begin
        tsum_d    = tsum_q + TsW'(temp_sample) - TsW'(old_temp);
        hsum_d    = hsum_q + HsW'(hum_sample) - HsW'(old_hum);
        wrapped_d = wrapped_q | (pos_q == LastPos);
      end
      OP_TICK: begin
        phase_d  = ~setter;
        heater_d = heater_n;
        hdprev_d = hd;
        hsince_d = hsince_n;
        humid_d  = humid_n;
        fan_d    = fan_n;
        fdprev_d = fd;
        fsince_d = fsince_n;
        vent_d   = vent_n;
        if (rot_start) begin
          rotate_d = 1'b1;
          rsince_d = now;
        end
      end
      OP_SWITCH: begin
        if (rotate_q && elapsed_ge(now, rsince_q, IgnoreC)) begin
          rotate_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tsum_q    <= '0;
      hsum_q    <= '0;
      pos_q     <= '0;
      wrapped_q <= 1'b0;
      heater_q  <= 1'b0;
      hdprev_q  <= 1'b0;
      humid_q   <= 1'b0;
      fan_q     <= 1'b0;
      fdprev_q  <= 1'b0;
      vent_q    <= 1'b0;
      rotate_q  <= 1'b0;
      phase_q   <= 1'b0;
      hsince_q  <= '0;
      fsince_q  <= '0;
      rsince_q  <= '0;
    end else if (s_fire) begin
      tsum_q    <= tsum_d;
      hsum_q    <= hsum_d;
      if (sample_we) begin
        pos_q <= pos_d;
      end
      wrapped_q <= wrapped_d;
      heater_q  <= heater_d;
      hdprev_q  <= hdprev_d;
      humid_q   <= humid_d;
      fan_q     <= fan_d;
      fdprev_q  <= fdprev_d;
      vent_q    <= vent_d;
      rotate_q  <= rotate_d;
      phase_q   <= phase_d;
      hsince_q  <= hsince_d;
      fsince_q  <= fsince_d;
      rsince_q  <= rsince_d;
    end
  end

  // Two-entry output buffer: main register and skid register.
  icc_drive_t            drv_n;
  icc_drive_t            out_drv_q, skid_drv_q;
  logic signed [TsW-1:0] out_tsum_q, skid_tsum_q;
  logic [HsW-1:0]        out_hsum_q, skid_hsum_q;
  logic                  out_valid_q, skid_valid_q;
  logic                  m_fire, load_out;

  assign drv_n = '{phase: phase_d, rotate: rotate_d, vent: vent_d, fan: fan_d,
                   humid: humid_d, heater: heater_d};

  assign m_fire        = out_valid_q & m_axis_tready;
  assign load_out      = ~out_valid_q | m_fire;
  assign s_axis_tready = ~skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q  <= skid_valid_q | s_fire;
      skid_valid_q <= 1'b0;
    end else if (s_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      if (skid_valid_q) begin
        out_drv_q  <= skid_drv_q;
        out_tsum_q <= skid_tsum_q;
        out_hsum_q <= skid_hsum_q;
      end else begin
        out_drv_q  <= drv_n;
        out_tsum_q <= tsum_d;
        out_hsum_q <= hsum_d;
      end
    end else if (s_fire) begin
      skid_drv_q  <= drv_n;
      skid_tsum_q <= tsum_d;
      skid_hsum_q <= hsum_d;
    end
  end

  logic signed [TempW-1:0] mean_temp;
  logic [HumW-1:0]         mean_hum;

  assign mean_temp     = TempW'(out_tsum_q / DepthC);
  assign mean_hum      = HumW'(out_hsum_q / AVG_DEPTH);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, mean_hum, mean_temp, out_drv_q.phase, out_drv_q.rotate,
                          out_drv_q.vent, out_drv_q.fan, out_drv_q.humid, out_drv_q.heater};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while main output register is empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && !m_fire) |=>
      $countones({out_valid_q, skid_valid_q}) ==
      $past($countones({out_valid_q, skid_valid_q})) + 1)
    else $error("accepted beat lost in output buffer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= LastPos)
    else $error("ring position beyond averaging depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(heater_q) |-> $past(s_fire && (op == OP_TICK)))
    else $error("heater switched on outside a control tick");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import icc_pkg::*;

  localparam int          AvgDepth         = 8;
  localparam int          VentTempMargin   = 10;
  localparam int          VentHumMargin    = 100;
  localparam int unsigned RotateEveryHours = 2;
  localparam int unsigned RotateIgnoreSec  = 10;
  localparam int unsigned HeaterFanWait    = 30;
  localparam int          CycleLimit       = 300000;
  localparam logic [OpW-1:0] OpSpare       = 2'd3;

  typedef struct {
    logic [OpW-1:0]   op;
    logic signed [TempW-1:0] temp;
    logic [HumW-1:0]  hum;
    logic [DayW-1:0]  day;
    logic [4:0]       hr;
    logic [5:0]       mn;
    logic [5:0]       sc;
  } ctl_item_t;

  typedef struct packed {
    logic [HumW-1:0]         mean_hum;
    logic signed [TempW-1:0] mean_temp;
    icc_drive_t              drive;
  } climate_out_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [RegIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [OpW-1:0]      s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  incubator_climate_controller_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted controller settings and state.
  int          sp_set_temp, sp_hat_temp, sp_set_hum, sp_hat_hum;
  int          band_temp, band_hum, setter_len;
  logic [31:0] fan_hold;
  int          t_hist [AvgDepth];
  int          h_hist [AvgDepth];
  int          hist_idx, t_acc, h_acc;
  bit          heat_q, heat_dem, hum_q, fan_q, fan_dem, vent_q, turn_q, hatch_q;
  logic [31:0] heat_t0, fan_t0, turn_t0;

  climate_out_t expected_drives [$];
  int           mismatches = 0;
  int           cycle_count = 0;
  int           gap_pct = 0;
  int           stall_pct = 0;

  function automatic void init_controller_model();
    sp_set_temp = 377;
    sp_hat_temp = 370;
    sp_set_hum  = 550;
    sp_hat_hum  = 700;
    band_temp   = 2;
    band_hum    = 20;
    fan_hold    = 10;
    setter_len  = 18;
    foreach (t_hist[i]) begin
      t_hist[i] = 0;
      h_hist[i] = 0;
    end
    hist_idx = 0;
    t_acc    = 0;
    h_acc    = 0;
    {heat_q, heat_dem, hum_q, fan_q, fan_dem, vent_q, turn_q, hatch_q} = '0;
    heat_t0 = '0;
    fan_t0  = '0;
    turn_t0 = '0;
  endfunction

  function automatic void load_register(input logic [RegIdxW-1:0] idx,
                                        input logic [CfgDataW-1:0] v);
    case (idx)
      REG_SETTER_TEMP:  sp_set_temp = int'($signed(v[TempW-1:0]));
      REG_HATCHER_TEMP: sp_hat_temp = int'($signed(v[TempW-1:0]));
      REG_SETTER_HUM:   sp_set_hum  = int'(v[HumW-1:0]);
      REG_HATCHER_HUM:  sp_hat_hum  = int'(v[HumW-1:0]);
      REG_TEMP_BAND:    band_temp   = int'(v[BandW-1:0]);
      REG_HUM_BAND:     band_hum    = int'(v[BandW-1:0]);
      REG_FAN_DELAY:    fan_hold    = 32'(v);
      REG_SETTER_DAYS:  setter_len  = int'(v[DayW-1:0]);
      default: ;
    endcase
  endfunction

  function automatic bit band_switch(input int acc, input int sp, input int h, input bit cur);
    if (!cur && acc < (sp - h) * AvgDepth) return 1'b1;
    if (cur && acc > (sp + h) * AvgDepth) return 1'b0;
    return cur;
  endfunction

  function automatic climate_out_t predict_controller(input ctl_item_t it);
    logic [31:0]  now;
    int           slot, tsp, hsp;
    bit           setter, hd, fd;
    climate_out_t r;
    now = 32'(it.sc) + 32'(it.mn) * 32'd60 + 32'(it.hr) * 32'd3600;
    case (it.op)
      OP_SAMPLE: begin
        slot = hist_idx;
        t_acc += int'(it.temp) - t_hist[slot];
        h_acc += int'(it.hum) - h_hist[slot];
        t_hist[slot] = int'(it.temp);
        h_hist[slot] = int'(it.hum);
        hist_idx = (slot + 1) % AvgDepth;
      end
      OP_TICK: begin
        setter = (int'(it.day) - 1) < setter_len;
        tsp = setter ? sp_set_temp : sp_hat_temp;
        hsp = setter ? sp_set_hum : sp_hat_hum;
        hatch_q = !setter;
        hd = band_switch(t_acc, tsp, band_temp, heat_q);
        if (hd != heat_dem) begin
          heat_t0  = now;
          heat_dem = hd;
        end
        if (hd != heat_q) begin
          heat_q = hd;
          if (heat_q && !fan_q && (now - heat_t0) > HeaterFanWait) heat_q = 1'b0;
        end
        hum_q = band_switch(h_acc, hsp, band_hum, hum_q);
        fd = heat_q || hum_q;
        if (fd != fan_dem) begin
          fan_t0  = now;
          fan_dem = fd;
        end
        if (fan_q != fd && (now - fan_t0) > fan_hold) fan_q = fd;
        vent_q = (t_acc > (tsp + VentTempMargin) * AvgDepth) ||
                 (h_acc > (hsp + VentHumMargin) * AvgDepth);
        if (setter && (it.hr % RotateEveryHours) == 0 && it.mn == 0 && it.sc == 0) begin
          turn_q  = 1'b1;
          turn_t0 = now;
        end
      end
      OP_SWITCH: begin
        if (turn_q && (now - turn_t0) >= RotateIgnoreSec) turn_q = 1'b0;
      end
      default: ;
    endcase
    r.drive.heater = heat_q;
    r.drive.humid  = hum_q;
    r.drive.fan    = fan_q;
    r.drive.vent   = vent_q;
    r.drive.rotate = turn_q;
    r.drive.phase  = hatch_q;
    r.mean_temp    = TempW'(t_acc / AvgDepth);
    r.mean_hum     = HumW'(h_acc / AvgDepth);
    return r;
  endfunction

  function automatic ctl_item_t make_item(input logic [OpW-1:0] op, input int t, input int h,
                                          input int d, input int secs);
    ctl_item_t it;
    it.op   = op;
    it.temp = TempW'(t);
    it.hum  = HumW'(h);
    it.day  = DayW'(d);
    it.hr   = 5'(secs / 3600);
    it.mn   = 6'((secs / 60) % 60);
    it.sc   = 6'(secs % 60);
    return it;
  endfunction

  function automatic ctl_item_t random_item();
    ctl_item_t it;
    it.op   = OpW'($urandom);
    it.temp = TempW'($urandom);
    it.hum  = HumW'($urandom);
    it.day  = DayW'($urandom);
    it.hr   = 5'($urandom);
    it.mn   = 6'($urandom);
    it.sc   = 6'($urandom);
    return it;
  endfunction

  function automatic int clamp_int(input int v, input int lo, input int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic void compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Output side: check each accepted result beat and apply receiver stalls.
  always @(posedge clk_i) begin
    climate_out_t got, want;
    int           rx_hold;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = climate_out_t'(m_axis_tdata[$bits(climate_out_t)-1:0]);
      if (expected_drives.size() == 0) begin
        $display("%0t: unexpected result beat, expected none actual %h", $time, m_axis_tdata);
        mismatches++;
      end else begin
        want = expected_drives.pop_front();
        compare_field("heater_on", want.drive.heater, got.drive.heater);
        compare_field("humidifier_on", want.drive.humid, got.drive.humid);
        compare_field("fan_on", want.drive.fan, got.drive.fan);
        compare_field("vent_on", want.drive.vent, got.drive.vent);
        compare_field("rotate_on", want.drive.rotate, got.drive.rotate);
        compare_field("hatcher_phase", want.drive.phase, got.drive.phase);
        compare_field("mean_temp", int'($signed(want.mean_temp)), int'($signed(got.mean_temp)));
        compare_field("mean_hum", int'(want.mean_hum), int'(got.mean_hum));
      end
    end
    if (rx_hold > 0) rx_hold--;
    else if ($urandom_range(0, 99) < stall_pct) rx_hold = $urandom_range(1, 13);
    m_axis_tready <= rst_ni && (rx_hold == 0);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_item(input ctl_item_t it);
    int gap;
    if ($urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 13);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.op;
    s_axis_tdata  <= {2'b00, it.sc, it.mn, it.hr, it.day, it.hum, it.temp};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_drives.push_back(predict_controller(it));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_drives.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [RegIdxW-1:0] idx, input int v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CfgDataW'(v);
    @(posedge clk_i);
    load_register(idx, CfgDataW'(v));
  endtask

  task automatic set_config(input int st, input int ht, input int sh, input int hh,
                            input int tb, input int hb, input int fd, input int sd);
    wait_drained();
    write_reg(REG_SETTER_TEMP, st);
    write_reg(REG_HATCHER_TEMP, ht);
    write_reg(REG_SETTER_HUM, sh);
    write_reg(REG_HATCHER_HUM, hh);
    write_reg(REG_TEMP_BAND, tb);
    write_reg(REG_HUM_BAND, hb);
    write_reg(REG_FAN_DELAY, fd);
    write_reg(REG_SETTER_DAYS, sd);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly samples near the active setpoints and ticks with advancing time of day,
  // with rotation boundaries, switch presses and some random beats mixed in.
  task automatic run_climate(input int n_items, input int start_day);
    int        clock_s, day, tsp, hsp, spread_t, spread_h, k;
    bit        in_setter;
    ctl_item_t it;
    clock_s = $urandom_range(0, 86399);
    day = clamp_int(start_day, 0, 255);
    repeat (n_items) begin
      in_setter = (day - 1) < setter_len;
      tsp = in_setter ? sp_set_temp : sp_hat_temp;
      hsp = in_setter ? sp_set_hum : sp_hat_hum;
      spread_t = band_temp + 25;
      spread_h = band_hum + 130;
      k = $urandom_range(0, 99);
      if (k < 6) begin
        it = random_item();
      end else if (k < 58) begin
        it = make_item(OP_SAMPLE,
                       clamp_int(tsp + $urandom_range(0, 2 * spread_t) - spread_t, -1024, 1023),
                       clamp_int(hsp + $urandom_range(0, 2 * spread_h) - spread_h, 0, 1023),
                       $urandom, clock_s);
      end else if (k < 90) begin
        k = $urandom_range(0, 99);
        if (k < 15) clock_s = (clock_s / 7200 + 1) * 7200;
        else if (k < 19) clock_s += $urandom_range(1, 40000);
        else clock_s += $urandom_range(1, 20);
        if (clock_s >= 86400) begin
          clock_s -= 86400;
          day = (day + 1) % 256;
        end
        it = make_item(OP_TICK, $urandom, $urandom, day, clock_s);
      end else begin
        clock_s = (clock_s + $urandom_range(0, 12)) % 86400;
        it = make_item(OP_SWITCH, $urandom, $urandom, $urandom, clock_s);
      end
      send_item(it);
    end
  endtask

  task automatic test_directed_extremes();
    ctl_item_t it;
    gap_pct   = 25;
    stall_pct = 25;
    it = make_item(OpSpare, 1023, 1023, 255, 0);
    it.hr = 5'h1f;
    it.mn = 6'h3f;
    it.sc = 6'h3f;
    send_item(it);
    repeat (AvgDepth) send_item(make_item(OP_SAMPLE, 1023, 1023, 0, 0));
    send_item(make_item(OP_TICK, 0, 0, 0, 0));
    send_item(make_item(OP_SWITCH, 0, 0, 0, 9));
    send_item(make_item(OP_SWITCH, 0, 0, 0, 10));
    repeat (AvgDepth) send_item(make_item(OP_SAMPLE, -1024, 0, 0, 0));
    send_item(make_item(OP_TICK, 0, 0, 255, 20));
    it = make_item(OP_TICK, 0, 0, 1, 0);
    it.hr = 5'h1f;
    it.mn = 6'h3f;
    it.sc = 6'h3f;
    send_item(it);
    send_item(make_item(OP_SAMPLE, -400, 1000, 0, 0));
    send_item(make_item(OP_SAMPLE, 800, 0, 0, 0));
  endtask

  task automatic test_default_climate();
    gap_pct   = 20;
    stall_pct = 20;
    run_climate(200, 17);
  endtask

  task automatic test_low_limits();
    set_config(-400, 800, 0, 1000, 0, 0, 0, 0);
    gap_pct   = 35;
    stall_pct = 35;
    run_climate(150, 1);
  endtask

  task automatic test_high_limits();
    set_config(800, -400, 1000, 0, 255, 255, 86399, 255);
    gap_pct   = 15;
    stall_pct = 40;
    run_climate(150, 254);
  endtask

  task automatic test_random_settings();
    repeat (2) begin
      set_config($urandom_range(0, 1200) - 400, $urandom_range(0, 1200) - 400,
                 $urandom_range(0, 1000), $urandom_range(0, 1000),
                 $urandom_range(0, 40), $urandom_range(0, 80),
                 $urandom_range(0, 60), $urandom_range(0, 30));
      gap_pct   = $urandom_range(0, 50);
      stall_pct = $urandom_range(0, 50);
      run_climate(150, setter_len);
    end
  endtask

  task automatic test_raw_register_bits();
    set_config($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    gap_pct   = 30;
    stall_pct = 30;
    run_climate(100, setter_len);
  endtask

  task automatic test_random_beats();
    gap_pct   = 30;
    stall_pct = 30;
    repeat (80) send_item(random_item());
  endtask

  task automatic test_steady_stream();
    set_config(377, 370, 550, 700, 3, 15, 3, 18);
    gap_pct   = 0;
    stall_pct = 0;
    run_climate(150, 18);
  endtask

  initial begin
    init_controller_model();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_extremes();
    test_default_climate();
    test_low_limits();
    test_high_limits();
    test_random_settings();
    test_raw_register_bits();
    test_random_beats();
    test_steady_stream();
    wait_drained();
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/icc_pkg.sv
hw/rtl/incubator_climate_controller_core.sv
dv/tb_top.sv
